[rtl/core/rob_pkg.sv]
package rob_pkg;

   localparam int DEFAULT_CAPACITY      = 16;
   localparam int DEFAULT_PHYS_REG_BITS = 6;

   // Widths of the fields on the channels, fixed whatever the parameters.
   localparam int TAG_BITS      = 16;
   localparam int REG_PORT_BITS = 6;
   localparam int VALUE_BITS    = 32;
   // Wide enough for any register number the parameter range allows.
   localparam int REG_EXT_BITS  = 8;

   typedef enum logic [1:0] {
      OP_DISPATCH  = 2'd0,
      OP_WRITEBACK = 2'd1,
      OP_RETIRE    = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]                      opcode;
      logic [TAG_BITS-1:0]             inst_tag;
      logic [REG_PORT_BITS-1:0]        phys_reg;
      logic                            done_at_dispatch;
      logic signed [VALUE_BITS-1:0]    result_value;
   } req_payload_type;

   typedef struct packed {
      logic                            accepted;
      logic [TAG_BITS-1:0]             retired_tag;
      logic [REG_PORT_BITS-1:0]        retired_reg;
      logic signed [VALUE_BITS-1:0]    retired_value;
      logic                            retired_done;
      logic                            head_done;
      logic                            is_full;
      logic                            has_entries;
   } rsp_payload_type;

endpackage

[rtl/core/rob_stream_if.sv]
interface rob_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/reorder_buffer_unit.sv]
// Reorder buffer: a circular queue of CAPACITY entries with parallel writeback match.
// req_chan carries one request per handshake: dispatch (allocate the tail entry),
// writeback (every allocated, not yet done entry whose register matches takes the
// value) or retire (pop the head entry, done or not).
// rsp_chan returns exactly one response per request, carrying the acceptance flag,
// the popped entry (zero when nothing was popped) and the full, non-empty and
// head-done status after the request.
// A request is captured in the input register; once the response register can advance,
// the entry flip-flops are updated and the response register loaded from it.
// Throughput is one request per cycle while the receiver keeps taking responses; the
// single pass over the entry flip-flops, with one comparator per entry, sets that figure.
// When the receiver stalls, the response register holds its contents, the captured
// request waits in the input register and req_chan.ready falls until the response
// is taken.
// A synchronous reset empties the buffer, clears every done and allocated mark and
// drops both registers; the entry data themselves are not cleared.
module reorder_buffer_unit #(
   parameter int CAPACITY      = rob_pkg::DEFAULT_CAPACITY,
   parameter int PHYS_REG_BITS = rob_pkg::DEFAULT_PHYS_REG_BITS
) (
   input logic          clock,
   input logic          reset,
   rob_stream_if.sink   req_chan,
   rob_stream_if.source rsp_chan
);

   localparam int PtrW = $clog2(CAPACITY);
   localparam int OccW = $clog2(CAPACITY + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(CAPACITY - 1);
   localparam logic [OccW-1:0] FullOcc = OccW'(CAPACITY);

   rob_pkg::req_payload_type req_ff;
   logic                     req_valid_ff;
   rob_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                     rsp_valid_ff;

   logic [rob_pkg::TAG_BITS-1:0]          tag_ff   [CAPACITY];
   logic [PHYS_REG_BITS-1:0]              reg_ff   [CAPACITY];
   logic [rob_pkg::VALUE_BITS-1:0]        value_ff [CAPACITY];
   logic [CAPACITY-1:0]                   done_ff, done_in;
   logic [CAPACITY-1:0]                   busy_ff, busy_in;
   logic [CAPACITY-1:0]                   wb_hit;
   logic [PtrW-1:0]                       head_ff, head_in, tail_ff, tail_in;
   logic [OccW-1:0]                       occ_ff, occ_in;

   logic                      advance;
   logic                      fire;
   logic                      do_dispatch, do_retire, do_writeback;
   logic [PHYS_REG_BITS-1:0]  req_reg;
   logic [rob_pkg::REG_EXT_BITS-1:0] req_reg_ext, head_reg_ext;

   // The response register is free or is being emptied in this cycle.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   assign req_reg_ext  = {{(rob_pkg::REG_EXT_BITS - rob_pkg::REG_PORT_BITS){1'b0}},
                          req_ff.phys_reg};
   assign req_reg      = req_reg_ext[PHYS_REG_BITS-1:0];
   assign head_reg_ext = {{(rob_pkg::REG_EXT_BITS - PHYS_REG_BITS){1'b0}}, reg_ff[head_ff]};

   always_comb begin
      do_dispatch  = 1'b0;
      do_writeback = 1'b0;
      do_retire    = 1'b0;
      unique case (req_ff.opcode)
         rob_pkg::OP_DISPATCH:  do_dispatch  = fire && (occ_ff != FullOcc);
         rob_pkg::OP_WRITEBACK: do_writeback = fire;
         rob_pkg::OP_RETIRE:    do_retire    = fire && (occ_ff != '0);
         default: begin
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         wb_hit[i] = do_writeback && busy_ff[i] && !done_ff[i] && (reg_ff[i] == req_reg);
         if (wb_hit[i]) begin
            done_in[i] = 1'b1;
         end
      end
      if (do_dispatch) begin
         busy_in[tail_ff] = 1'b1;
         done_in[tail_ff] = req_ff.done_at_dispatch;
         tail_in          = (tail_ff == LastPtr) ? '0 : tail_ff + 1'b1;
         occ_in           = occ_ff + 1'b1;
      end
      if (do_retire) begin
         busy_in[head_ff] = 1'b0;
         head_in          = (head_ff == LastPtr) ? '0 : head_ff + 1'b1;
         occ_in           = occ_ff - 1'b1;
      end

      rsp_in               = '0;
      rsp_in.accepted      = do_dispatch || do_writeback || do_retire;
      if (do_retire) begin
         rsp_in.retired_tag   = tag_ff[head_ff];
         rsp_in.retired_reg   = head_reg_ext[rob_pkg::REG_PORT_BITS-1:0];
         rsp_in.retired_value = value_ff[head_ff];
         rsp_in.retired_done  = done_ff[head_ff];
      end
      rsp_in.head_done     = (occ_in != '0) && done_in[head_in];
      rsp_in.is_full       = (occ_in == FullOcc);
      rsp_in.has_entries   = (occ_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         done_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         busy_ff <= busy_in;
         done_ff <= done_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         req_ff <= req_chan.data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
      if (do_dispatch) begin
         tag_ff[tail_ff] <= req_ff.inst_tag;
         reg_ff[tail_ff] <= req_reg;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (wb_hit[i]) begin
            value_ff[i] <= req_ff.result_value;
         end
      end
   end

   // The allocated marks always agree with the occupancy count.
   assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == 32'(occ_ff))
      else $error("allocated marks disagree with occupancy");

   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FullOcc)
      else $error("occupancy beyond capacity");

   // Equal pointers mean an empty or a full buffer.
   assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (occ_ff == '0 || occ_ff == FullOcc))
      else $error("pointers disagree with occupancy");

   // A response can only be loaded from a captured request.
   assert property (@(posedge clock) disable iff (reset)
      (!req_valid_ff && advance) |=> !rsp_valid_ff)
      else $error("response without a request");

endmodule
